>>> src/tss_pkg.sv
// Shared types, constants and decode functions for the temperature display scanner.
`default_nettype none

package tss_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int POS_W       = $clog2(DIGIT_COUNT);

  // Item command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Digit code shown as a minus sign.
  localparam logic [3:0] DIGIT_MINUS = 4'd10;

  // Dot positions.
  localparam logic [1:0] DOT_NONE  = 2'd0;
  localparam logic [1:0] DOT_AFTER1 = 2'd1;
  localparam logic [1:0] DOT_AFTER2 = 2'd2;
  localparam logic [1:0] DOT_AFTER3 = 2'd3;

  typedef logic [DIGIT_COUNT-1:0][3:0] codes_t;

  // Result of decoding one load item.
  typedef struct packed {
    logic       update;
    logic [1:0] dot;
    codes_t     codes;
  } load_t;

  // Control from the input register to the display stage.
  typedef struct packed {
    logic go;
    logic tick;
  } stage_ctl_t;

  // Segment pattern for a digit code, decimal point clear.
  function automatic logic [7:0] seg_pattern(input logic [3:0] code);
    logic [7:0] s;
    case (code)
      4'd0:        s = 8'hFC;
      4'd1:        s = 8'h60;
      4'd2:        s = 8'hDA;
      4'd3:        s = 8'hF2;
      4'd4:        s = 8'd102;
      4'd5:        s = 8'd182;
      4'd6:        s = 8'd190;
      4'd7:        s = 8'd224;
      4'd8:        s = 8'd254;
      4'd9:        s = 8'd246;
      DIGIT_MINUS: s = 8'h02;
      default:     s = 8'h00;
    endcase
    return s;
  endfunction

  // Thousands, hundreds and tens digits of 625 * m, as [2], [1], [0].
  function automatic logic [2:0][3:0] frac_digits(input logic [3:0] m);
    logic [2:0][3:0] d;
    case (m)
      4'd0:    d = {4'd0, 4'd0, 4'd0};
      4'd1:    d = {4'd0, 4'd6, 4'd2};
      4'd2:    d = {4'd1, 4'd2, 4'd5};
      4'd3:    d = {4'd1, 4'd8, 4'd7};
      4'd4:    d = {4'd2, 4'd5, 4'd0};
      4'd5:    d = {4'd3, 4'd1, 4'd2};
      4'd6:    d = {4'd3, 4'd7, 4'd5};
      4'd7:    d = {4'd4, 4'd3, 4'd7};
      4'd8:    d = {4'd5, 4'd0, 4'd0};
      4'd9:    d = {4'd5, 4'd6, 4'd2};
      4'd10:   d = {4'd6, 4'd2, 4'd5};
      4'd11:   d = {4'd6, 4'd8, 4'd7};
      4'd12:   d = {4'd7, 4'd5, 4'd0};
      4'd13:   d = {4'd8, 4'd1, 4'd2};
      4'd14:   d = {4'd8, 4'd7, 4'd5};
      4'd15:   d = {4'd9, 4'd3, 4'd7};
      default: d = {4'd0, 4'd0, 4'd0};
    endcase
    return d;
  endfunction

  // Quotient by ten for values below 128, by reciprocal multiplication.
  function automatic logic [3:0] div10(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return p[14:11];
  endfunction

endpackage

`default_nettype wire

>>> src/tss_if.sv
// Valid/ready channel interfaces for load/tick items and display results.
`default_nettype none

interface tss_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] raw_reading;

  modport source (output valid, output cmd, output raw_reading, input ready);
  modport sink   (input valid, input cmd, input raw_reading, output ready);
endinterface

interface tss_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] segments;
  logic [3:0] digit_select;

  modport source (output valid, output segments, output digit_select, input ready);
  modport sink   (input valid, input segments, input digit_select, output ready);
endinterface

`default_nettype wire

>>> src/tss_decode.sv
// Decodes a raw sensor word into four digit codes and a dot position.
`default_nettype none

module tss_decode
  import tss_pkg::*;
(
  input  logic [15:0] raw_reading,
  output load_t       load
);

  logic [7:0]      lo;
  logic [7:0]      hi;
  logic [6:0]      ip_raw;
  logic [3:0]      nib;
  logic            neg;
  logic [7:0]      mag;
  logic [3:0]      frac_m;
  logic [2:0][3:0] fd;
  logic            hun;
  logic [6:0]      rem;
  logic [3:0]      tens;
  logic [3:0]      ones;
  logic [6:0]      tens_x10;

  always_comb begin
    lo     = raw_reading[7:0];
    hi     = raw_reading[15:8];
    ip_raw = {hi[2:0], lo[7:4]};
    nib    = lo[3:0];
    neg    = &hi[7:3];

    // Negation: the fraction borrows from the integer unless it is zero.
    if (neg) begin
      mag    = (8'd127 - {1'b0, ip_raw}) + {7'd0, (nib == 4'd0)};
      frac_m = 4'd0 - nib;
    end else begin
      mag    = {1'b0, ip_raw};
      frac_m = nib;
    end

    fd       = frac_digits(frac_m);
    hun      = (mag >= 8'd100);
    rem      = hun ? 7'(mag - 8'd100) : mag[6:0];
    tens     = div10(rem);
    tens_x10 = 7'({3'd0, tens} * 7'd10);
    ones     = 4'(rem - tens_x10);

    load.update = 1'b1;
    load.dot    = DOT_NONE;
    load.codes  = '0;
    if (!neg) begin
      if (hun) begin
        load.codes = {fd[2], ones, tens, 4'd1};
        load.dot   = DOT_AFTER3;
      end else if (mag >= 8'd10) begin
        load.codes = {fd[1], fd[2], ones, tens};
        load.dot   = DOT_AFTER2;
      end else begin
        load.codes = {fd[0], fd[1], fd[2], ones};
        load.dot   = DOT_AFTER1;
      end
    end else begin
      if (hun) begin
        // Out of range below zero: the display keeps what it shows.
        load.update = 1'b0;
      end else if (mag >= 8'd10) begin
        load.codes = {fd[2], ones, tens, DIGIT_MINUS};
        load.dot   = DOT_AFTER3;
      end else begin
        load.codes = {fd[1], fd[2], ones, DIGIT_MINUS};
        load.dot   = DOT_AFTER2;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/tss_display.sv
// Display state, scan position and the result register.
`default_nettype none

module tss_display
  import tss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stage_ctl_t ctl,
  input  load_t      load,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] segments,
  output logic [3:0] digit_select
);

  codes_t           digit_codes;
  logic [1:0]       dot_place;
  logic [POS_W-1:0] scan_position;

  logic [7:0]       seg_next;
  logic [3:0]       select_next;
  logic [1:0]       pos_plus1;

  always_comb begin
    pos_plus1 = 2'(scan_position) + 2'd1;
    seg_next  = seg_pattern(digit_codes[scan_position]);
    // The last digit never gets a dot: its successor wraps to zero.
    if ((dot_place != DOT_NONE) && (dot_place == pos_plus1)) begin
      seg_next[0] = 1'b1;
    end
    select_next = ~(4'b0001 << scan_position);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_codes   <= '0;
      dot_place     <= DOT_NONE;
      scan_position <= '0;
    end else if (ctl.go) begin
      if (ctl.tick) begin
        scan_position <= scan_position + POS_W'(1);
      end else if (load.update) begin
        digit_codes <= load.codes;
        dot_place   <= load.dot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.go && ctl.tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go && ctl.tick) begin
      segments     <= seg_next;
      digit_select <= select_next;
    end
  end

endmodule

`default_nettype wire

>>> src/temp_reading_seven_segment_scan.sv
// Top level of the multiplexed seven-segment temperature display scanner.
// A tick item passes through the input register, then the display stage fills the result register.
// Throughput: one item per cycle, loads and ticks freely mixed, while results are taken.
// A load item yields no result but, unless out of range, updates the display for every later tick.
// Reset (synchronous) shows 0000 with no dot and starts the scan at the first digit.
// The display stage stalls only when a tick finds the result register still full.
`default_nettype none

module temp_reading_seven_segment_scan
  import tss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  tss_item_if.sink            item_in,
  tss_result_if.source        result_out
);

  // Input register: one item waits here while the display stage works on it.
  logic        s1_valid;
  logic        s1_cmd;
  logic [15:0] s1_raw;

  logic        out_free;
  logic        s1_go;
  load_t       load;
  stage_ctl_t  ctl;

  // A load never needs the result register, so it always leaves the input
  // register; a tick leaves when the result register is empty or being read.
  assign out_free      = !result_out.valid || result_out.ready;
  assign s1_go         = s1_valid && ((s1_cmd == CMD_LOAD) || out_free);
  assign item_in.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_in.ready) begin
      s1_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      s1_cmd <= item_in.cmd;
      s1_raw <= item_in.raw_reading;
    end
  end

  // The load decode is pure logic on the registered word.
  tss_decode u_decode (
    .raw_reading (s1_raw),
    .load        (load)
  );

  assign ctl.go   = s1_go;
  assign ctl.tick = (s1_cmd == CMD_TICK);

  // Display state and the result register live together, so a tick always
  // sees every load that was accepted before it.
  tss_display u_display (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .load         (load),
    .out_ready    (result_out.ready),
    .out_valid    (result_out.valid),
    .segments     (result_out.segments),
    .digit_select (result_out.digit_select)
  );

  // A tick leaving the input register must fill the result register.
  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s1_go && ctl.tick) |=> result_out.valid)
    else $error("tick item did not produce a result");

  // Exactly one digit is selected in every result.
  a_one_digit: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> $onehot(~result_out.digit_select))
    else $error("result selects other than one digit");

  // A stalled tick keeps its place and its word in the input register.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_raw) && $stable(s1_cmd)))
    else $error("stalled item lost from the input register");

  // A load never creates a result of its own.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (s1_go && !ctl.tick && result_out.ready) |=> !result_out.valid)
    else $error("load item produced a result");

endmodule

`default_nettype wire
